// File: hw/rtl/arp_responder_with_aging_cache_unit_defines.svh
// Assertion macros shared by the ARP responder RTL.
// Depends on nothing; included by the top level only.
`ifndef ARP_RESPONDER_WITH_AGING_CACHE_UNIT_DEFINES_SVH
`define ARP_RESPONDER_WITH_AGING_CACHE_UNIT_DEFINES_SVH

// Implication checked on every edge outside reset.
`define ARC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define ARC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/arc_pkg.sv
// Package of the ARP responder: constants, status codes and shared types.
// Depends on nothing.
package arc_pkg;

  localparam int CacheEntriesDefault = 16;
  localparam logic [31:0] DefaultIpReset = 32'd167772687;
  localparam logic [31:0] TimeoutReset   = 32'd300000;
  localparam logic [10:0] MinFrameLen    = 11'd28;
  localparam logic [7:0]  HwLenEth       = 8'd6;
  localparam logic [7:0]  ProtoLenIpv4   = 8'd4;
  localparam logic [15:0] HwTypeEth      = 16'd1;
  localparam logic [15:0] ProtoTypeIpv4  = 16'h0800;
  localparam logic [15:0] OpRequest      = 16'd1;
  localparam logic [15:0] OpReply        = 16'd2;

  typedef enum logic [2:0] {
    REG_DEFAULT_IP = 3'd0,
    REG_INTF_IP = 3'd1,
    REG_LOCAL_IP = 3'd2,
    REG_OWN_MAC = 3'd3,
    REG_TIMEOUT = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_DROPPED = 3'd0,
    ST_LEARNED = 3'd1,
    ST_LEARNED_REPLY = 3'd2,
    ST_IGNORED = 3'd3,
    ST_HIT = 3'd4,
    ST_MISS = 3'd5
  } status_t;

  // Classified operation handed from front to back.
  typedef enum logic [1:0] {
    OP_QUERY = 2'd0,
    OP_DROP = 2'd1,
    OP_LEARN = 2'd2,
    OP_IGNORE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_SCAN = 2'd1,
    BK_DONE = 2'd2
  } bk_state_t;

  typedef struct packed {
    op_t         op;
    logic        own_hit;
    logic        reply;
    logic [31:0] key_ip;
    logic [47:0] mac;
    logic [31:0] reply_sip;
    logic [47:0] now_ms;
  } job_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        send_reply;
    logic [31:0] reply_src_ip;
    logic [47:0] reply_dst_mac;
    logic [31:0] reply_dst_ip;
    logic [47:0] found_mac;
    logic        cache_full;
  } res_t;

endpackage

// File: hw/rtl/arc_if.sv
// Valid/ready channel interfaces for input items, results and config writes.
// Depends on nothing.
interface arc_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [10:0] frame_len;
  logic [15:0] hw_type;
  logic [15:0] ptype;
  logic [7:0]  hw_len;
  logic [7:0]  plen;
  logic [15:0] arp_op;
  logic [47:0] src_mac;
  logic [31:0] src_ip;
  logic [31:0] tgt_ip;
  logic [31:0] query_ip;
  logic [47:0] now_ms;
  modport source (output valid, kind, frame_len, hw_type, ptype, hw_len, plen,
                  arp_op, src_mac, src_ip, tgt_ip, query_ip, now_ms, input ready);
  modport sink (input valid, kind, frame_len, hw_type, ptype, hw_len, plen,
                arp_op, src_mac, src_ip, tgt_ip, query_ip, now_ms, output ready);
endinterface

interface arc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        send_reply;
  logic [31:0] reply_src_ip;
  logic [47:0] reply_dst_mac;
  logic [31:0] reply_dst_ip;
  logic [47:0] found_mac;
  logic        cache_full;
  modport source (output valid, status, send_reply, reply_src_ip, reply_dst_mac,
                  reply_dst_ip, found_mac, cache_full, input ready);
  modport sink (input valid, status, send_reply, reply_src_ip, reply_dst_mac,
                reply_dst_ip, found_mac, cache_full, output ready);
endinterface

interface arc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [47:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/arc_front.sv
// Front end: validates and classifies one input word into a job.
// Depends on arc_pkg.
module arc_front import arc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  arc_in_if.sink      in_ch,
  input  logic [31:0] default_ip,
  input  logic [31:0] intf_ip,
  input  logic [31:0] local_ip,
  output logic        job_valid,
  input  logic        job_ready,
  output job_t        job
);
  logic   full_r;
  job_t   job_r;
  job_t   job_nxt;
  logic   if_set, bad;

  assign in_ch.ready = !full_r || job_ready;
  assign job_valid = full_r;
  assign job = job_r;

  // Classification of the incoming word.
  always_comb begin
    if_set = intf_ip != 32'd0;
    bad = in_ch.frame_len < MinFrameLen || in_ch.hw_type != HwTypeEth ||
          in_ch.ptype != ProtoTypeIpv4 || in_ch.hw_len != HwLenEth ||
          in_ch.plen != ProtoLenIpv4;
    job_nxt = '0;
    job_nxt.now_ms = in_ch.now_ms;
    job_nxt.mac = in_ch.src_mac;
    job_nxt.reply_sip = if_set ? intf_ip : default_ip;
    if (in_ch.kind) begin
      job_nxt.op = OP_QUERY;
      job_nxt.key_ip = in_ch.query_ip;
      job_nxt.own_hit = (if_set && in_ch.query_ip == intf_ip) ||
                        in_ch.query_ip == default_ip || in_ch.query_ip == local_ip;
    end else if (bad) begin
      job_nxt.op = OP_DROP;
    end else if (in_ch.arp_op == OpRequest || in_ch.arp_op == OpReply) begin
      job_nxt.op = OP_LEARN;
      job_nxt.key_ip = in_ch.src_ip;
      job_nxt.reply = in_ch.arp_op == OpRequest &&
                      ((if_set && in_ch.tgt_ip == intf_ip) ||
                       in_ch.tgt_ip == default_ip);
    end else begin
      job_nxt.op = OP_IGNORE;
    end
  end

  // One-entry queue between front and back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      full_r <= 1'b1;
    end else if (job_ready) begin
      full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      job_r <= job_nxt;
    end
  end
endmodule

// File: hw/rtl/arc_back.sv
// Back end: ages, searches and updates the cache one entry per cycle.
// Depends on arc_pkg.
module arc_back import arc_pkg::*; #(
  parameter int CACHE_ENTRIES = CacheEntriesDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_valid,
  output logic        job_ready,
  input  job_t        job,
  input  logic [47:0] own_mac,
  input  logic [31:0] age_limit,
  arc_out_if.source   out_ch
);
  localparam int IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CW = $clog2(CACHE_ENTRIES + 1);

  bk_state_t state_r, state_nxt;
  job_t      job_r;
  logic [CW-1:0] idx_r, idx_nxt;
  logic      found_r, found_nxt, free_r, free_nxt;
  logic [IW-1:0] hit_idx_r, hit_idx_nxt, free_idx_r, free_idx_nxt;
  logic [47:0] hit_mac_r, hit_mac_nxt;
  logic [CACHE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [31:0] ip_mem [CACHE_ENTRIES];
  logic [47:0] mac_mem [CACHE_ENTRIES];
  logic [47:0] time_mem [CACHE_ENTRIES];
  logic [31:0] ip_rd_r;
  logic [47:0] mac_rd_r, time_rd_r;
  logic [IW-1:0] cur, rd_idx;
  logic [47:0] age;
  logic      live, wr_en;
  logic [IW-1:0] wr_idx;
  logic      out_valid_r;
  res_t      res_r, res_nxt;

  // The memory read is addressed by the next index, so the registered read data matches the current index.
  assign cur = idx_r[IW-1:0];
  assign rd_idx = idx_nxt[IW-1:0];
  assign age = job_r.now_ms - time_rd_r;
  assign job_ready = state_r == BK_IDLE;
  assign out_ch.valid = out_valid_r;
  assign out_ch.status = res_r.status;
  assign out_ch.send_reply = res_r.send_reply;
  assign out_ch.reply_src_ip = res_r.reply_src_ip;
  assign out_ch.reply_dst_mac = res_r.reply_dst_mac;
  assign out_ch.reply_dst_ip = res_r.reply_dst_ip;
  assign out_ch.found_mac = res_r.found_mac;
  assign out_ch.cache_full = res_r.cache_full;

  // Scan sequencer: one entry aged and compared per cycle, then the result formed and the cache written.
  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    found_nxt = found_r;
    free_nxt = free_r;
    hit_idx_nxt = hit_idx_r;
    free_idx_nxt = free_idx_r;
    hit_mac_nxt = hit_mac_r;
    valid_nxt = valid_r;
    live = 1'b0;
    wr_en = 1'b0;
    wr_idx = hit_idx_r;
    res_nxt = '0;
    case (state_r)
      BK_IDLE: begin
        if (job_valid) begin
          state_nxt = BK_SCAN;
          idx_nxt = '0;
          found_nxt = 1'b0;
          free_nxt = 1'b0;
        end
      end
      BK_SCAN: begin
        live = valid_r[cur] && age <= {16'd0, age_limit};
        valid_nxt[cur] = live;
        if (live && !found_r && ip_rd_r == job_r.key_ip) begin
          found_nxt = 1'b1;
          hit_idx_nxt = cur;
          hit_mac_nxt = mac_rd_r;
        end
        if (!live && !free_r) begin
          free_nxt = 1'b1;
          free_idx_nxt = cur;
        end
        if (idx_r == CW'(CACHE_ENTRIES - 1)) begin
          state_nxt = BK_DONE;
        end
        idx_nxt = idx_r + 1'b1;
      end
      BK_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = BK_IDLE;
          case (job_r.op)
            OP_QUERY: begin
              if (job_r.own_hit) begin
                res_nxt.status = ST_HIT;
                res_nxt.found_mac = own_mac;
              end else if (found_r) begin
                res_nxt.status = ST_HIT;
                res_nxt.found_mac = hit_mac_r;
              end else begin
                res_nxt.status = ST_MISS;
              end
            end
            OP_LEARN: begin
              res_nxt.status = job_r.reply ? ST_LEARNED_REPLY : ST_LEARNED;
              if (found_r) begin
                wr_en = 1'b1;
              end else if (free_r) begin
                wr_en = 1'b1;
                wr_idx = free_idx_r;
                valid_nxt[free_idx_r] = 1'b1;
              end else begin
                res_nxt.cache_full = 1'b1;
              end
              if (job_r.reply) begin
                res_nxt.send_reply = 1'b1;
                res_nxt.reply_src_ip = job_r.reply_sip;
                res_nxt.reply_dst_mac = job_r.mac;
                res_nxt.reply_dst_ip = job_r.key_ip;
              end
            end
            OP_IGNORE: res_nxt.status = ST_IGNORED;
            default: res_nxt.status = ST_DROPPED;
          endcase
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      valid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      if (state_r == BK_DONE && state_nxt == BK_IDLE) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers and entry storage with registered read.
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    found_r <= found_nxt;
    free_r <= free_nxt;
    hit_idx_r <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
    hit_mac_r <= hit_mac_nxt;
    ip_rd_r <= ip_mem[rd_idx];
    mac_rd_r <= mac_mem[rd_idx];
    time_rd_r <= time_mem[rd_idx];
    if (job_valid && state_r == BK_IDLE) begin
      job_r <= job;
    end
    if (state_r == BK_DONE && state_nxt == BK_IDLE) begin
      res_r <= res_nxt;
    end
    if (wr_en) begin
      ip_mem[wr_idx] <= job_r.key_ip;
      mac_mem[wr_idx] <= job_r.mac;
      time_mem[wr_idx] <= job_r.now_ms;
    end
  end
endmodule

// File: hw/rtl/arp_responder_with_aging_cache_unit.sv
// Top level of the ARP responder with aging cache: config registers, front, back.
// Depends on arc_pkg, the channel interfaces, arc_front, arc_back and the macro header.
//
//   channel | dir | payload
//   in_ch   | in  | ARP packet fields or query, with now_ms
//   out_ch  | out | status, reply fields, found_mac, cache_full
//   cfg_ch  | in  | register index and write data
//
// Each item passes the back end's idle, scan and done states: the entry scan that ages,
// searches and finds a free slot visits one entry per cycle. The front queue holds one
// word so the next item can enter during the scan. Reset is synchronous and clears all
// entry valid bits at once. A stalled result holds the back end in its final state.
`include "arp_responder_with_aging_cache_unit_defines.svh"
module arp_responder_with_aging_cache_unit import arc_pkg::*; #(
  parameter int CACHE_ENTRIES = CacheEntriesDefault
) (
  input  logic       clk,
  input  logic       rst_n,
  arc_in_if.sink     in_ch,
  arc_out_if.source  out_ch,
  arc_cfg_if.sink    cfg_ch
);
  logic [31:0] default_ip_r, intf_ip_r, local_ip_r, timeout_r;
  logic [47:0] own_mac_r;
  logic        job_valid, job_ready;
  job_t        job;

  assign cfg_ch.ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_ip_r <= DefaultIpReset;
      intf_ip_r <= '0;
      local_ip_r <= '0;
      own_mac_r <= '0;
      timeout_r <= TimeoutReset;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_DEFAULT_IP: default_ip_r <= cfg_ch.data[31:0];
        REG_INTF_IP: intf_ip_r <= cfg_ch.data[31:0];
        REG_LOCAL_IP: local_ip_r <= cfg_ch.data[31:0];
        REG_OWN_MAC: own_mac_r <= cfg_ch.data;
        REG_TIMEOUT: timeout_r <= cfg_ch.data[31:0];
        default: ;
      endcase
    end
  end

  arc_front u_front (
    .clk, .rst_n, .in_ch,
    .default_ip(default_ip_r), .intf_ip(intf_ip_r), .local_ip(local_ip_r),
    .job_valid, .job_ready, .job
  );

  arc_back #(.CACHE_ENTRIES(CACHE_ENTRIES)) u_back (
    .clk, .rst_n, .job_valid, .job_ready, .job,
    .own_mac(own_mac_r), .age_limit(timeout_r), .out_ch
  );

  // A reply is only ever flagged with the learned-and-reply status.
  `ARC_ASSERT_IMP(a_reply_status, out_ch.valid && out_ch.send_reply,
                  out_ch.status == ST_LEARNED_REPLY, "reply without matching status")
  // A job handed to the back end leaves the front queue the next cycle unless refilled.
  `ARC_ASSERT_NXT(a_job_taken, job_valid && job_ready && !in_ch.valid, !job_valid,
                  "front queue did not drain")
  // Cache-full only occurs on learning statuses.
  `ARC_ASSERT_IMP(a_full_learn, out_ch.valid && out_ch.cache_full,
                  out_ch.status == ST_LEARNED || out_ch.status == ST_LEARNED_REPLY,
                  "cache_full on wrong status")
endmodule

// File: verif/tb_arp_responder_with_aging_cache_unit.sv
// Self-checking testbench of the ARP responder with aging cache.
// Depends on arc_pkg, the channel interfaces and the top level of the block.
module tb_arp_responder_with_aging_cache_unit;
  import arc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Entries = CacheEntriesDefault;
  localparam int CycleLimit = 3000000;
  localparam int DrainCycles = Entries + 10;

  typedef struct packed {
    logic        kind;
    logic [10:0] frame_len;
    logic [15:0] hw_type;
    logic [15:0] ptype;
    logic [7:0]  hw_len;
    logic [7:0]  plen;
    logic [15:0] arp_op;
    logic [47:0] src_mac;
    logic [31:0] src_ip;
    logic [31:0] tgt_ip;
    logic [31:0] query_ip;
    logic [47:0] now_ms;
  } arp_item_t;

  // Mirror of the cache and registers; holds the results still to come.
  class arp_cache_scoreboard;
    logic [31:0] default_ip, intf_ip, local_ip, age_limit;
    logic [47:0] own_mac;
    bit          slot_valid[Entries];
    logic [31:0] slot_ip[Entries];
    logic [47:0] slot_mac[Entries];
    logic [47:0] slot_time[Entries];
    res_t        pending_results[$];
    int          mismatches, results, hits, full_events, replies;

    function new();
      default_ip = DefaultIpReset;
      intf_ip = '0;
      local_ip = '0;
      own_mac = '0;
      age_limit = TimeoutReset;
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [47:0] data);
      case (idx)
        REG_DEFAULT_IP:   default_ip = data[31:0];
        REG_INTF_IP:      intf_ip = data[31:0];
        REG_LOCAL_IP:     local_ip = data[31:0];
        REG_OWN_MAC:      own_mac = data;
        REG_TIMEOUT:      age_limit = data[31:0];
        default: ;
      endcase
    endfunction

    function int lookup(logic [31:0] ip);
      for (int i = 0; i < Entries; i++)
        if (slot_valid[i] && slot_ip[i] == ip) return i;
      return -1;
    endfunction

    // Returns 1 when the mapping found no free slot.
    function bit learn(logic [31:0] ip, logic [47:0] mac, logic [47:0] now);
      int s;
      s = lookup(ip);
      if (s < 0) begin
        for (s = 0; s < Entries; s++)
          if (!slot_valid[s]) break;
        if (s >= Entries) return 1'b1;
        slot_valid[s] = 1'b1;
        slot_ip[s] = ip;
      end
      slot_mac[s] = mac;
      slot_time[s] = now;
      return 1'b0;
    endfunction

    function void note_input(arp_item_t it);
      res_t r;
      int s;
      logic [47:0] age;
      r = '0;
      // Expire old entries first, on every item.
      for (int i = 0; i < Entries; i++) begin
        age = it.now_ms - slot_time[i];
        if (slot_valid[i] && age > {16'd0, age_limit}) slot_valid[i] = 1'b0;
      end
      if (it.kind) begin
        if ((intf_ip != 0 && it.query_ip == intf_ip) ||
            it.query_ip == default_ip || it.query_ip == local_ip) begin
          r.status = ST_HIT;
          r.found_mac = own_mac;
        end else begin
          s = lookup(it.query_ip);
          if (s >= 0) begin
            r.status = ST_HIT;
            r.found_mac = slot_mac[s];
          end else begin
            r.status = ST_MISS;
          end
        end
      end else if (it.frame_len < MinFrameLen || it.hw_type != HwTypeEth ||
                   it.ptype != ProtoTypeIpv4 || it.hw_len != HwLenEth ||
                   it.plen != ProtoLenIpv4) begin
        r.status = ST_DROPPED;
      end else if (it.arp_op == OpRequest || it.arp_op == OpReply) begin
        r.cache_full = learn(it.src_ip, it.src_mac, it.now_ms);
        r.status = ST_LEARNED;
        if (it.arp_op == OpRequest &&
            ((intf_ip != 0 && it.tgt_ip == intf_ip) ||
             it.tgt_ip == default_ip)) begin
          r.status = ST_LEARNED_REPLY;
          r.send_reply = 1'b1;
          r.reply_src_ip = (intf_ip != 0) ? intf_ip : default_ip;
          r.reply_dst_mac = it.src_mac;
          r.reply_dst_ip = it.src_ip;
        end
      end else begin
        r.status = ST_IGNORED;
      end
      if (r.status == ST_HIT) hits++;
      if (r.cache_full) full_events++;
      if (r.send_reply) replies++;
      pending_results.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t exp_r;
      results++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word: %p", got);
        return;
      end
      exp_r = pending_results.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch #%0d\n  expected %p\n  actual   %p",
                   mismatches, exp_r, got);
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic clk, rst_n;
  arc_in_if  in_ch();
  arc_out_if out_ch();
  arc_cfg_if cfg_ch();

  arp_responder_with_aging_cache_unit #(.CACHE_ENTRIES(Entries)) i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  arp_cache_scoreboard sb;
  int unsigned cycles = 0;
  bit          no_send_gaps, no_recv_stalls;
  logic [47:0] now_ms;
  logic [31:0] ip_pool[40];
  int          items_sent;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // Observe both handshakes at the clock edge.
  always @(posedge clk) begin
    arp_item_t it;
    res_t r;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        it = '{in_ch.kind, in_ch.frame_len, in_ch.hw_type, in_ch.ptype,
               in_ch.hw_len, in_ch.plen, in_ch.arp_op, in_ch.src_mac,
               in_ch.src_ip, in_ch.tgt_ip, in_ch.query_ip, in_ch.now_ms};
        sb.note_input(it);
      end
      if (out_ch.valid && out_ch.ready) begin
        r = '{out_ch.status, out_ch.send_reply, out_ch.reply_src_ip,
              out_ch.reply_dst_mac, out_ch.reply_dst_ip, out_ch.found_mac,
              out_ch.cache_full};
        sb.check_result(r);
      end
    end
  end

  // Result receiver with random stalls per word.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = no_recv_stalls ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(out_ch.valid && out_ch.ready)) @(posedge clk);
    end
  end

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  task automatic send_item(arp_item_t it);
    int gap;
    in_ch.valid <= 1'b1;
    {in_ch.kind, in_ch.frame_len, in_ch.hw_type, in_ch.ptype, in_ch.hw_len,
     in_ch.plen, in_ch.arp_op, in_ch.src_mac, in_ch.src_ip,
     in_ch.tgt_ip, in_ch.query_ip, in_ch.now_ms} <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    gap = no_send_gaps ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(reg_idx_t idx, logic [47:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  // Hold off until every result is back and the scan has settled.
  // The first edge lets the monitor note the last accepted word.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic arp_item_t good_packet(logic [15:0] op, logic [31:0] sip,
                                            logic [47:0] smac, logic [31:0] tip);
    arp_item_t it;
    it = '0;
    it.frame_len = MinFrameLen;
    it.hw_type = HwTypeEth;
    it.ptype = ProtoTypeIpv4;
    it.hw_len = HwLenEth;
    it.plen = ProtoLenIpv4;
    it.arp_op = op;
    it.src_mac = smac;
    it.src_ip = sip;
    it.tgt_ip = tip;
    it.query_ip = $urandom();
    it.now_ms = now_ms;
    return it;
  endfunction

  function automatic logic [31:0] pick_ip();
    case ($urandom_range(0, 9))
      0: return sb.default_ip;
      1: return sb.intf_ip;
      2: return sb.local_ip;
      3: return $urandom();
      default: return ip_pool[$urandom_range(0, 39)];
    endcase
  endfunction

  // Mostly well-formed packets and queries, some malformed noise.
  function automatic arp_item_t random_item();
    arp_item_t it;
    int pick;
    logic [63:0] jump;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0) begin
      jump = 64'($urandom_range(0, 2)) * {32'd0, sb.age_limit} +
             64'($urandom_range(0, 3));
      now_ms = now_ms + jump[47:0];
    end else begin
      now_ms = now_ms + 48'($urandom_range(0, 3));
    end
    it = good_packet($urandom_range(0, 3) == 0 ? OpRequest : ($urandom_range(0, 1) ?
                     OpRequest : OpReply), pick_ip(), rand48(), pick_ip());
    it.frame_len = $urandom_range(0, 3) == 0 ? 11'($urandom_range(28, 2047)) : MinFrameLen;
    if (pick < 25) begin
      it.kind = 1'b1;
      it.query_ip = pick_ip();
      if ($urandom_range(0, 1)) begin
        {it.frame_len, it.hw_type, it.ptype} = 43'({$urandom(), $urandom()});
        {it.hw_len, it.plen, it.arp_op} = $urandom();
      end
    end else if (pick < 35) begin
      case ($urandom_range(0, 5))
        0: it.frame_len = 11'($urandom_range(0, 27));
        1: it.hw_type = 16'($urandom());
        2: it.ptype = 16'($urandom());
        3: it.hw_len = 8'($urandom());
        4: it.plen = 8'($urandom());
        default: {it.frame_len, it.hw_type, it.ptype, it.hw_len, it.plen} =
                 59'({$urandom(), $urandom()});
      endcase
    end else if (pick < 40) begin
      it.arp_op = 16'($urandom());
    end
    return it;
  endfunction

  task automatic directed();
    arp_item_t it;
    send_item(good_packet(OpRequest, 32'hC0A80001, 48'h0000_0000_0001, sb.default_ip));
    send_item(good_packet(OpReply, 32'hC0A80002, 48'hFFFF_FFFF_FFFF, 32'h0));
    // Known address learned again with a new MAC.
    send_item(good_packet(OpReply, 32'hC0A80002, 48'h1234_5678_9ABC, 32'h0));
    it = good_packet(OpRequest, 32'hC0A80003, rand48(), 32'h0);
    it.kind = 1'b1; it.query_ip = 32'hC0A80002;
    send_item(it);
    it.query_ip = 32'hC0A800FF;
    send_item(it);
    it.query_ip = sb.default_ip;
    send_item(it);
    // Zero query matches a zero local address.
    it.query_ip = 32'h0;
    send_item(it);
    it = good_packet(OpRequest, 32'h1, 48'h1, sb.default_ip);
    it.frame_len = 11'd27; send_item(it);
    it.frame_len = 11'h7FF; send_item(it);
    it.frame_len = 11'd0; send_item(it);
    it = good_packet(OpRequest, 32'h2, 48'h2, sb.default_ip);
    it.hw_type = 16'hFFFF; send_item(it);
    it.hw_type = HwTypeEth; it.ptype = 16'h86DD; send_item(it);
    it.ptype = ProtoTypeIpv4; it.hw_len = 8'd5; send_item(it);
    it.hw_len = 8'hFF; send_item(it);
    it.hw_len = HwLenEth; it.plen = 8'd6; send_item(it);
    it.plen = ProtoLenIpv4; it.arp_op = 16'd0; send_item(it);
    it.arp_op = 16'd3; send_item(it);
    it.arp_op = 16'hFFFF; send_item(it);
    // Request to zero target while the interface address is unset.
    send_item(good_packet(OpRequest, 32'hFFFFFFFF, 48'hA, 32'h0));
    // Jump far enough that every entry ages out.
    now_ms = now_ms + 48'd400000;
    it = good_packet(OpRequest, 32'h0, 48'h0, 32'h0);
    it.kind = 1'b1; it.query_ip = 32'hC0A80002;
    send_item(it);
  endtask

  task automatic run_phase(int count, bit pause_mid);
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 0) begin
        no_send_gaps = ($urandom_range(0, 3) == 0);
        no_recv_stalls = ($urandom_range(0, 3) == 0);
      end
      if (pause_mid && n == count / 2) drain();
      send_item(random_item());
    end
    drain();
  endtask

  initial begin
    sb = new();
    rst_n = 0;
    items_sent = 0;
    now_ms = 48'd1000;
    no_send_gaps = 0;
    no_recv_stalls = 0;
    in_ch.valid = 1'b0;
    {in_ch.kind, in_ch.frame_len, in_ch.hw_type, in_ch.ptype, in_ch.hw_len,
     in_ch.plen, in_ch.arp_op, in_ch.src_mac, in_ch.src_ip,
     in_ch.tgt_ip, in_ch.query_ip, in_ch.now_ms} = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_DEFAULT_IP;
    cfg_ch.data = '0;
    foreach (ip_pool[i]) ip_pool[i] = $urandom();
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Reset settings first, then the directed items.
    directed();
    drain();
    run_phase(250, 1);

    // Tiny timeout with an interface address and all-ones MAC.
    write_reg(REG_TIMEOUT, 48'd1);
    write_reg(REG_INTF_IP, {16'd0, ip_pool[0]});
    write_reg(REG_OWN_MAC, 48'hFFFF_FFFF_FFFF);
    run_phase(250, 0);

    // Largest timeout, so the cache fills up.
    write_reg(REG_TIMEOUT, 48'hFFFF_FFFF);
    write_reg(REG_DEFAULT_IP, 48'h0);
    write_reg(REG_LOCAL_IP, {16'd0, ip_pool[1]});
    run_phase(300, 0);

    // Time wraps past the top of its range.
    now_ms = 48'hFFFF_FFFF_FF00;
    write_reg(REG_TIMEOUT, 48'd40);
    write_reg(REG_DEFAULT_IP, 48'hFFFF_FFFF);
    write_reg(REG_INTF_IP, 48'h0);
    write_reg(REG_LOCAL_IP, 48'hFFFF_FFFF);
    write_reg(REG_OWN_MAC, rand48());
    run_phase(300, 0);

    write_reg(REG_TIMEOUT, 48'd1000);
    write_reg(REG_DEFAULT_IP, {16'd0, ip_pool[2]});
    write_reg(REG_INTF_IP, 48'hFFFF_FFFF);
    write_reg(REG_LOCAL_IP, 48'h0);
    write_reg(REG_OWN_MAC, 48'h0);
    run_phase(275, 0);

    write_reg(REG_TIMEOUT, 48'd300000);
    write_reg(REG_INTF_IP, {16'd0, ip_pool[3]});
    run_phase(255, 0);

    $display("covered %0d items, %0d results: %0d hits, %0d replies, %0d cache-full",
             items_sent, sb.results, sb.hits, sb.replies, sb.full_events);
    $display("mismatches %0d, results left over %0d", sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
